/* rtl/column_consensus_vote_top_macros.svh */
// assertion macros for the column consensus block
`ifndef COLUMN_CONSENSUS_VOTE_TOP_MACROS_SVH
`define COLUMN_CONSENSUS_VOTE_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define CCV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that must also hold during reset
`define CCV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/ccv_pkg.sv */
package ccv_pkg;

    localparam int NUM_CAND = 5;
    localparam logic [2:0] BASE_GAP = 3'd4;
    localparam logic signed [31:0] GAP_HIT_LL = -32'sd53;
    localparam logic signed [31:0] GAP_MISS_LL = -32'sd4487;
    localparam logic [18:0] PHRED_PER_NAT_Q16 = 19'd284619;
    localparam logic [6:0] CAP_RESET = 7'd60;

    typedef logic signed [31:0] t_ll;
    typedef logic [15:0] t_qs;
    typedef logic signed [33:0] t_lse;

    // finished column handed from the accumulator
    typedef struct packed {
        logic valid;
        t_ll [NUM_CAND-1:0] ll;
        t_qs [NUM_CAND-1:0] qs;
    } t_col;

    // log-likelihood of a matching base, by quality
    function automatic t_ll hit_ll(input logic [6:0] q);
        t_ll v;
        case (q)
            7'd0: v = -32'sd707354;  7'd1: v = -32'sd1619;  7'd2: v = -32'sd1021;
            7'd3: v = -32'sd712;     7'd4: v = -32'sd520;   7'd5: v = -32'sd389;
            7'd6: v = -32'sd296;     7'd7: v = -32'sd228;   7'd8: v = -32'sd177;
            7'd9: v = -32'sd138;     7'd10: v = -32'sd108;  7'd11: v = -32'sd85;
            7'd12: v = -32'sd67;     7'd13: v = -32'sd53;   7'd14: v = -32'sd42;
            7'd15: v = -32'sd33;     7'd16: v = -32'sd26;   7'd17: v = -32'sd21;
            7'd18: v = -32'sd16;     7'd19: v = -32'sd13;   7'd20: v = -32'sd10;
            7'd21: v = -32'sd8;      7'd22: v = -32'sd6;    7'd23: v = -32'sd5;
            7'd24: v = -32'sd4;      7'd25: v = -32'sd3;    7'd26: v = -32'sd3;
            7'd27: v = -32'sd2;      7'd28: v = -32'sd2;    7'd29: v = -32'sd1;
            7'd30: v = -32'sd1;      7'd31: v = -32'sd1;    7'd32: v = -32'sd1;
            7'd33: v = -32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // log-likelihood of a differing base
    function automatic t_ll miss_ll(input logic [6:0] q);
        logic [25:0] p;
        p = 26'(q) * 26'd241444 + 26'd1454147;
        return -t_ll'({16'd0, p[25:10]});
    endfunction

    // ln(1 + exp(-i/4)) in Q10
    function automatic logic [9:0] softplus(input logic [4:0] i);
        logic [9:0] v;
        case (i)
            5'd0: v = 10'd710;  5'd1: v = 10'd590;  5'd2: v = 10'd485;  5'd3: v = 10'd396;
            5'd4: v = 10'd321;  5'd5: v = 10'd258;  5'd6: v = 10'd206;  5'd7: v = 10'd164;
            5'd8: v = 10'd130;  5'd9: v = 10'd103;  5'd10: v = 10'd81;  5'd11: v = 10'd63;
            5'd12: v = 10'd50;  5'd13: v = 10'd39;  5'd14: v = 10'd30;  5'd15: v = 10'd24;
            5'd16: v = 10'd19;  5'd17: v = 10'd15;  5'd18: v = 10'd11;  5'd19: v = 10'd9;
            5'd20: v = 10'd7;   5'd21: v = 10'd5;   5'd22: v = 10'd4;   5'd23: v = 10'd3;
            5'd24: v = 10'd3;   5'd25: v = 10'd2;   5'd26: v = 10'd2;   5'd27: v = 10'd1;
            5'd28: v = 10'd1;   5'd29: v = 10'd1;   5'd30: v = 10'd1;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    // two-input log-sum-exp
    function automatic t_lse lse2(input t_lse a, input t_lse b);
        logic signed [34:0] d;
        logic [34:0] t;
        logic [34:0] i;
        t_lse m;
        d = 35'(a) - 35'(b);
        m = (a > b) ? a : b;
        t = d[34] ? 35'(-d) : d;
        i = (t + 35'd128) >> 8;
        return m + ((i < 35'd32) ? t_lse'({24'd0, softplus(i[4:0])}) : t_lse'(0));
    endfunction

endpackage

/* rtl/ccv_accum.sv */
module ccv_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [2:0]      i_base,
    input  logic [6:0]      i_quality,
    input  logic            i_last,
    output ccv_pkg::t_col   o_col
);

    ccv_pkg::t_ll [ccv_pkg::NUM_CAND-1:0] r_ll, n_ll;
    ccv_pkg::t_qs [ccv_pkg::NUM_CAND-1:0] r_qs, n_qs;
    ccv_pkg::t_col r_col;

    // per-candidate deltas and saturating sums
    always_comb begin
        ccv_pkg::t_ll hit;
        ccv_pkg::t_ll miss;
        ccv_pkg::t_ll d;
        logic signed [32:0] s;
        logic [16:0] qsum;
        hit = ccv_pkg::hit_ll(i_quality);
        miss = ccv_pkg::miss_ll(i_quality);
        n_ll = r_ll;
        n_qs = r_qs;
        for (int k = 0; k < ccv_pkg::NUM_CAND; k++) begin
            if (i_base < ccv_pkg::BASE_GAP) begin
                d = (3'(k) == i_base) ? hit : miss;
            end else if (i_base == ccv_pkg::BASE_GAP) begin
                d = (3'(k) == ccv_pkg::BASE_GAP) ? ccv_pkg::GAP_HIT_LL
                                                 : ccv_pkg::GAP_MISS_LL;
            end else begin
                d = '0;
            end
            s = 33'(r_ll[k]) + 33'(d);
            n_ll[k] = (s < -33'sd2147483648) ? 32'sh8000_0000 : s[31:0];
            qsum = 17'(r_qs[k]) + 17'(i_quality);
            if (i_base < ccv_pkg::BASE_GAP && 3'(k) == i_base) begin
                n_qs[k] = qsum[16] ? 16'hffff : qsum[15:0];
            end
        end
    end

    // running sums, cleared when a column closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ll <= '0;
            r_qs <= '0;
            r_col.valid <= 1'b0;
        end else if (i_adv) begin
            r_col.valid <= i_valid && i_last;
            r_col.ll <= n_ll;
            r_col.qs <= n_qs;
            if (i_valid) begin
                r_ll <= i_last ? '0 : n_ll;
                r_qs <= i_last ? '0 : n_qs;
            end
        end
    end

    assign o_col = r_col;

endmodule

/* rtl/column_consensus_vote_top.sv */
// path: input register, accumulator, finalisation pipeline, result register
// one observation per cycle unless stalled; results of back-to-back columns overlap
// stall on the input only while a result waits and the output is stalled
// reset (synchronous, active low) clears the sums and pipeline and sets the cap to 60
module column_consensus_vote_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_obs_base,
    input  logic [6:0] i_obs_quality,
    input  logic       i_column_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_consensus_base,
    output logic [6:0] o_consensus_quality,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    logic adv;
    logic [6:0] r_cap;
    logic r_in_v;
    logic [2:0] r_in_base;
    logic [6:0] r_in_q;
    logic r_in_last;
    ccv_pkg::t_col col;

    logic [6:2] r_v;
    logic [2:0] r_best [2:6];
    ccv_pkg::t_lse r_bll [2:5];
    ccv_pkg::t_lse r_lo [3:5];
    ccv_pkg::t_lse [3:0] r_los;
    ccv_pkg::t_lse [3:0] r_los3;
    ccv_pkg::t_lse [3:0] r_los4;
    logic [15:0] r_n;
    logic [2:0] n_best;
    logic [6:0] n_q;
    logic r_out_v;
    logic [2:0] r_out_base;
    logic [6:0] r_out_q;

    assign adv = !(r_out_v && i_out_stall);
    assign o_in_stall = !adv;
    assign o_cfg_ready = 1'b1;

    // quality cap register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= ccv_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (adv) begin
            r_in_v <= i_in_valid;
            r_in_base <= i_obs_base;
            r_in_q <= i_obs_quality;
            r_in_last <= i_column_end;
        end
    end

    ccv_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (r_in_v),
        .i_base    (r_in_base),
        .i_quality (r_in_q),
        .i_last    (r_in_last),
        .o_col     (col)
    );

    // winner: highest sum, then higher quality sum, then lower index
    always_comb begin
        n_best = '0;
        for (int k = 1; k < ccv_pkg::NUM_CAND; k++) begin
            if (col.ll[k] > col.ll[n_best] ||
                (col.ll[k] == col.ll[n_best] && col.qs[k] > col.qs[n_best])) begin
                n_best = 3'(k);
            end
        end
    end

    // finalisation pipeline
    always_ff @(posedge i_clk) begin
        logic signed [34:0] nd;
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[5:2], col.valid};
            // losers in candidate order
            r_best[2] <= n_best;
            r_bll[2] <= 34'(col.ll[n_best]);
            for (int j = 0; j < 4; j++) begin
                r_los[j] <= (3'(j) < n_best) ? 34'(col.ll[j]) : 34'(col.ll[j+1]);
            end
            // fold of the losing sums
            r_best[3] <= r_best[2];
            r_bll[3] <= r_bll[2];
            r_lo[3] <= ccv_pkg::lse2(r_los[0], r_los[1]);
            r_los3 <= r_los;
            r_best[4] <= r_best[3];
            r_bll[4] <= r_bll[3];
            r_lo[4] <= ccv_pkg::lse2(r_lo[3], r_los3[2]);
            r_los4 <= r_los3;
            r_best[5] <= r_best[4];
            r_bll[5] <= r_bll[4];
            r_lo[5] <= ccv_pkg::lse2(r_lo[4], r_los4[3]);
            // margin of the winner, held to 16 bits
            r_best[6] <= r_best[5];
            nd = 35'(ccv_pkg::lse2(r_lo[5], r_bll[5])) - 35'(r_lo[5]);
            r_n <= nd[34] ? 16'd0 : ((nd > 35'sd65535) ? 16'hffff : nd[15:0]);
        end
    end

    // phred conversion and cap
    always_comb begin
        logic [34:0] p;
        logic [8:0] qv;
        p = 35'(r_n) * 35'(ccv_pkg::PHRED_PER_NAT_Q16) + 35'h200_0000;
        qv = p[34:26];
        n_q = (qv > 9'(r_cap)) ? r_cap : qv[6:0];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_v[6];
            r_out_base <= r_best[6];
            r_out_q <= n_q;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_consensus_base = r_out_base;
    assign o_consensus_quality = r_out_q;

endmodule

/* rtl/ccv_checker.sv */
`include "column_consensus_vote_top_macros.svh"

module ccv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_consensus_base
);

    // a stalled result stays
    `CCV_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> o_out_valid, "result dropped")
    // input stall only with a result waiting
    `CCV_ASSERT(a_stall_src, o_in_stall |-> (o_out_valid && i_out_stall), "spurious stall")
    // winner is a real candidate
    `CCV_ASSERT(a_base_rng, o_out_valid |-> (o_consensus_base <= ccv_pkg::BASE_GAP), "bad base")
    // nothing comes out straight after reset
    `CCV_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_out_valid, "valid after reset")

endmodule

bind column_consensus_vote_top ccv_checker u_ccv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_consensus_base (o_consensus_base)
);
